// File: sv/clfa_pkg.sv
// ----------------------------------------------------------------------------
// Chunk free list allocator package
// Shared constants, operation and status codes, state machine type and the
// request, result and link memory access structs.
// ----------------------------------------------------------------------------
package clfa_pkg;

    localparam int MAX_CHUNKS     = 1024;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 2;
    localparam int RESERVE_CHUNKS = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_RESERVE = 2'd1,
        STAT_REJECT  = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ALLOC
    } clfa_state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] chunk_index;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
        logic [CNT_W-1:0]    free_count;
    } result_t;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] wdata;
    } link_req_t;

endpackage

// File: sv/clfa_link_ram.sv
// ----------------------------------------------------------------------------
// Next-link memory
// Single-port synchronous memory holding the successor of every free chunk.
// Read data is registered and appears in the cycle after an enabled read.
// ----------------------------------------------------------------------------
module clfa_link_ram (
    input  logic                      clk,
    input  clfa_pkg::link_req_t       req,
    output logic [clfa_pkg::IDX_W-1:0] rdata
);
    import clfa_pkg::*;

    logic [IDX_W-1:0] mem [MAX_CHUNKS];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule

// File: sv/clfa_ctrl.sv
// ----------------------------------------------------------------------------
// Free list controller
// Holds the head index, free count and pool size register, and sequences the
// init walk, pops and pushes against the next-link memory.
// ----------------------------------------------------------------------------
module clfa_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  clfa_pkg::request_t        request,
    output logic                      done,
    output clfa_pkg::result_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [clfa_pkg::CNT_W-1:0] cfg_data,
    output clfa_pkg::link_req_t       link_req,
    input  logic [clfa_pkg::IDX_W-1:0] link_rdata
);
    import clfa_pkg::*;

    localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(MAX_CHUNKS);
    localparam logic [CNT_W-1:0] RESERVE  = CNT_W'(RESERVE_CHUNKS);

    clfa_state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] ctr_reg, ctr_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;
    logic [CNT_W-1:0] heap_chunks_reg;

    logic [CNT_W-1:0] pool_n;
    logic             pool_empty;
    logic             alloc_ok;
    logic             free_ok;
    logic             init_last;
    op_code_t         op;

    assign op         = op_code_t'(request.op);
    assign pool_n     = (heap_chunks_reg > POOL_MAX) ? POOL_MAX : heap_chunks_reg;
    assign pool_empty = (pool_n == '0);
    assign alloc_ok   = (free_reg > RESERVE);
    assign free_ok    = ({1'b0, request.chunk_index} < pool_n) && (free_reg < pool_n);
    assign init_last  = ({1'b0, ctr_reg} == (pool_n - CNT_W'(1)));

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_INIT && !pool_empty)
                    begin
                        state_next = ST_INIT;
                    end
                    else if (op == OP_ALLOC && alloc_ok)
                    begin
                        state_next = ST_ALLOC;
                    end
                end
            end
            ST_INIT:
            begin
                if (init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result.
    always_comb
    begin
        head_next   = head_reg;
        free_next   = free_reg;
        ctr_next    = ctr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        link_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_INIT:
                        begin
                            ctr_next = '0;
                            if (pool_empty)
                            begin
                                head_next   = '0;
                                free_next   = '0;
                                done_next   = 1'b1;
                                result_next = '{STAT_OK, '0, '0};
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (alloc_ok)
                            begin
                                link_req.en   = 1'b1;
                                link_req.addr = head_reg;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{STAT_RESERVE, '0, free_reg};
                            end
                        end
                        OP_FREE:
                        begin
                            done_next = 1'b1;
                            if (free_ok)
                            begin
                                link_req.en    = 1'b1;
                                link_req.we    = 1'b1;
                                link_req.addr  = request.chunk_index;
                                link_req.wdata = head_reg;
                                head_next      = request.chunk_index;
                                free_next      = free_reg + CNT_W'(1);
                                result_next    = '{STAT_OK, '0, free_reg + CNT_W'(1)};
                            end
                            else
                            begin
                                result_next = '{STAT_REJECT, '0, free_reg};
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{STAT_OK, '0, free_reg};
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                // Chunk i links to i-1; chunk 0 terminates the list.
                link_req.en    = 1'b1;
                link_req.we    = 1'b1;
                link_req.addr  = ctr_reg;
                link_req.wdata = (ctr_reg == '0) ? '0 : ctr_reg - IDX_W'(1);
                ctr_next       = ctr_reg + IDX_W'(1);
                if (init_last)
                begin
                    head_next   = ctr_reg;
                    free_next   = pool_n;
                    done_next   = 1'b1;
                    result_next = '{STAT_OK, '0, pool_n};
                end
            end
            ST_ALLOC:
            begin
                // The link of the old head has arrived from memory.
                head_next   = link_rdata;
                free_next   = free_reg - CNT_W'(1);
                done_next   = 1'b1;
                result_next = '{STAT_OK, head_reg, free_reg - CNT_W'(1)};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            free_reg        <= '0;
            done_reg        <= 1'b0;
            heap_chunks_reg <= POOL_MAX;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                heap_chunks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg    <= ctr_next;
        result_reg <= result_next;
    end

endmodule

// File: sv/chunk_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Chunk free list allocator
// Fixed-size chunk pool kept as a linked free list in an on-chip link memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its op field selects
// init, allocate or free; chunk_index names the chunk to free. Every request
// produces exactly one result, shown for one cycle with done high.
// Free, refused allocate and the unused op give their result in the cycle
// after the request and leave busy low, so one may be issued every cycle.
// A successful allocate passes through ST_ALLOC with busy high: the link of
// the head is read from the single-port link memory, and the result is
// registered once it arrives. Init writes one link per cycle over the pool,
// heap_chunks saturated at 1024, with busy high until the result (an empty
// pool gives its result as free does). The pool size register is written
// over cfg_valid/cfg_ready and is always ready; the user is to write it only
// while idle, which the block does not enforce. Reset sets an empty pool and
// a pool size of 1024 chunks. The link memory is not cleared: run init before
// use. The receiver cannot stall; a result must be taken in the cycle it appears.
// ----------------------------------------------------------------------------
module chunk_free_list_allocator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  clfa_pkg::request_t        request,
    output logic                      done,
    output clfa_pkg::result_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [clfa_pkg::CNT_W-1:0] cfg_data
);
    import clfa_pkg::*;

    link_req_t        link_req;
    logic [IDX_W-1:0] link_rdata;

    clfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .link_req   (link_req),
        .link_rdata (link_rdata)
    );

    clfa_link_ram u_link_ram (
        .clk   (clk),
        .req   (link_req),
        .rdata (link_rdata)
    );

endmodule
